// ----- rtl/core/bdec_pkg.sv -----
// ---------------------------------------------------------------------------
// Boolean arithmetic decoder package
// Shared constants, command codes, sequencer states and interface structs.
// ---------------------------------------------------------------------------
`default_nettype none

package bdec_pkg;

    localparam int FIFO_DEPTH       = 16;
    localparam int MAX_LITERAL_BITS = 16;

    localparam int PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int LIT_W  = $clog2(MAX_LITERAL_BITS + 1);

    localparam int DECODED_W = 16;
    localparam int NBITS_W   = 5;

    localparam logic [8:0] RANGE_INIT   = 9'd255;
    localparam logic [8:0] RENORM_LIMIT = 9'h080;
    localparam logic [3:0] COUNT_INIT   = 4'd8;
    localparam logic [1:0] LOAD_LAST    = 2'd3;

    typedef enum logic [1:0] {
        CMD_PUSH    = 2'd0,
        CMD_START   = 2'd1,
        CMD_BOOL    = 2'd2,
        CMD_LITERAL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_DECIDE = 2'd0,
        OP_HALF   = 2'd1,
        OP_SHIFT  = 2'd2,
        OP_LOAD   = 2'd3
    } alu_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_RENORM,
        ST_LITERAL,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [7:0]           byte_in;
        logic [7:0]           probability;
        logic [NBITS_W-1:0]   literal_bits;
    } req_t;

    typedef struct packed {
        logic [DECODED_W-1:0] decoded;
        logic                 underflow;
        logic                 overflow;
    } rsp_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] rd_data;
    } fifo_stat_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wr_data;
    } fifo_ctrl_t;

    typedef struct packed {
        logic [8:0]  range;
        logic [31:0] value;
        logic [3:0]  count;
        logic        bit_out;
        logic        pop;
        logic        under;
    } alu_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/bdec_fifo.sv -----
// ---------------------------------------------------------------------------
// Compressed byte FIFO
// Holds pushed bytes until the decoder consumes them, with fill tracking.
// ---------------------------------------------------------------------------
`default_nettype none

module bdec_fifo (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  bdec_pkg::fifo_ctrl_t ctrl,
    output bdec_pkg::fifo_stat_t stat
);
    import bdec_pkg::*;

    logic [7:0]        mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    assign stat.empty   = (fill_reg == '0);
    assign stat.full    = (fill_reg == FILL_W'(FIFO_DEPTH));
    assign stat.rd_data = mem_reg[rd_ptr_reg];

    assign do_push = ctrl.push && !stat.full;
    assign do_pop  = ctrl.pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= ctrl.wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdec_alu.sv -----
// ---------------------------------------------------------------------------
// Decoder step unit
// One compare, subtract and shift step of the boolean decoder, shared by
// bool decisions, renormalization, literal bits and start-up byte loads.
// ---------------------------------------------------------------------------
`default_nettype none

module bdec_alu (
    input  bdec_pkg::alu_op_t    op,
    input  wire  [8:0]           range,
    input  wire  [31:0]          value,
    input  wire  [3:0]           count,
    input  wire  [8:0]           split,
    input  bdec_pkg::fifo_stat_t fifo,
    output bdec_pkg::alu_res_t   res
);
    import bdec_pkg::*;

    logic [8:0]  half_split;
    logic [8:0]  split_sel;
    logic [31:0] big;
    logic        ge;
    logic [31:0] diff;
    logic [8:0]  r_sel;
    logic [31:0] v_pre;
    logic [31:0] v_sh;
    logic [3:0]  cnt_dec;
    logic        hit;
    logic [7:0]  fetched;

    assign half_split = 9'((10'(range) + 10'd1) >> 1);
    assign split_sel  = (op == OP_HALF) ? half_split : split;
    assign big        = {split_sel[7:0], 24'd0};
    assign ge         = (value >= big);
    assign diff       = value - big;
    assign r_sel      = ge ? (range - split_sel) : split_sel;
    assign fetched    = fifo.empty ? 8'd0 : fifo.rd_data;
    assign cnt_dec    = count - 4'd1;
    assign hit        = (cnt_dec == 4'd0);
    assign v_pre      = ge ? diff : value;

    always_comb begin
        res.range   = range;
        res.value   = value;
        res.count   = count;
        res.bit_out = 1'b0;
        res.pop     = 1'b0;
        res.under   = 1'b0;
        v_sh        = value;
        case (op)
            OP_DECIDE: begin
                res.range   = (r_sel == 9'd0) ? 9'd1 : r_sel;
                res.value   = v_pre;
                res.bit_out = ge;
            end
            OP_HALF, OP_SHIFT: begin
                if (op == OP_HALF) begin
                    res.range   = {r_sel[7:0], 1'b0};
                    v_sh        = {v_pre[30:0], 1'b0};
                    res.bit_out = ge;
                end else begin
                    res.range = {range[7:0], 1'b0};
                    v_sh      = {value[30:0], 1'b0};
                end
                res.count = hit ? COUNT_INIT : cnt_dec;
                res.value = hit ? (v_sh | {24'd0, fetched}) : v_sh;
                res.pop   = hit;
                res.under = hit && fifo.empty;
            end
            OP_LOAD: begin
                res.value = {value[23:0], fetched};
                res.pop   = 1'b1;
                res.under = fifo.empty;
            end
            default: begin
                res.value = value;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/bdec_seq.sv -----
// ---------------------------------------------------------------------------
// Decoder sequencer
// Holds the coder state and steps the shared unit once per cycle for each
// start, bool or literal request until its response is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module bdec_seq (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  bdec_pkg::req_t       req,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output bdec_pkg::rsp_t       rsp,
    input  bdec_pkg::fifo_stat_t fifo_stat,
    output bdec_pkg::fifo_ctrl_t fifo_ctrl
);
    import bdec_pkg::*;

    state_t               state_reg, state_next;
    logic [8:0]           range_reg, range_next;
    logic [31:0]          value_reg, value_next;
    logic [3:0]           count_reg, count_next;
    logic [8:0]           split_reg, split_next;
    logic [LIT_W-1:0]     lit_left_reg, lit_left_next;
    logic [1:0]           load_idx_reg, load_idx_next;
    logic [DECODED_W-1:0] result_reg, result_next;
    logic                 under_reg, under_next;
    logic                 over_reg, over_next;

    alu_op_t              alu_op;
    alu_res_t             alu_res;
    logic                 step_en;
    logic                 accept;
    logic [8:0]           range_m1;
    logic [15:0]          prod;
    logic [LIT_W-1:0]     lit_sat;

    bdec_alu u_alu (
        .op    (alu_op),
        .range (range_reg),
        .value (value_reg),
        .count (count_reg),
        .split (split_reg),
        .fifo  (fifo_stat),
        .res   (alu_res)
    );

    assign accept   = req_valid && req_ready;
    assign range_m1 = range_reg - 9'd1;
    assign prod     = 16'(range_m1[7:0]) * 16'(req.probability);
    assign lit_sat  = (int'(req.literal_bits) > MAX_LITERAL_BITS) ?
                      LIT_W'(MAX_LITERAL_BITS) : LIT_W'(req.literal_bits);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    case (req.cmd)
                        CMD_PUSH:    state_next = ST_DONE;
                        CMD_START:   state_next = ST_LOAD;
                        CMD_BOOL:    state_next = ST_DECIDE;
                        CMD_LITERAL: state_next = (lit_sat == '0) ? ST_DONE : ST_LITERAL;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD: begin
                if (load_idx_reg == LOAD_LAST) begin
                    state_next = ST_DONE;
                end
            end
            ST_DECIDE: state_next = ST_RENORM;
            ST_RENORM: begin
                if (range_reg >= RENORM_LIMIT) begin
                    state_next = ST_DONE;
                end
            end
            ST_LITERAL: begin
                if (lit_left_reg == LIT_W'(1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready         = 1'b0;
        rsp_valid         = 1'b0;
        alu_op            = OP_SHIFT;
        step_en           = 1'b0;
        fifo_ctrl.push    = 1'b0;
        fifo_ctrl.wr_data = req.byte_in;
        case (state_reg)
            ST_IDLE: begin
                req_ready      = 1'b1;
                fifo_ctrl.push = req_valid && (req.cmd == CMD_PUSH);
            end
            ST_LOAD: begin
                alu_op  = OP_LOAD;
                step_en = 1'b1;
            end
            ST_DECIDE: begin
                alu_op  = OP_DECIDE;
                step_en = 1'b1;
            end
            ST_RENORM: begin
                alu_op  = OP_SHIFT;
                step_en = (range_reg < RENORM_LIMIT);
            end
            ST_LITERAL: begin
                alu_op  = OP_HALF;
                step_en = 1'b1;
            end
            ST_DONE: begin
                rsp_valid = 1'b1;
            end
            default: begin
                req_ready = 1'b0;
            end
        endcase
        fifo_ctrl.pop = step_en && alu_res.pop;
    end

    always_comb begin
        range_next    = range_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        split_next    = split_reg;
        lit_left_next = lit_left_reg;
        load_idx_next = load_idx_reg;
        result_next   = result_reg;
        under_next    = under_reg;
        over_next     = over_reg;
        if (accept) begin
            result_next   = '0;
            under_next    = 1'b0;
            over_next     = (req.cmd == CMD_PUSH) && fifo_stat.full;
            split_next    = 9'd1 + 9'(prod[15:8]);
            lit_left_next = lit_sat;
            load_idx_next = '0;
        end
        if (step_en) begin
            value_next = alu_res.value;
            under_next = under_reg | alu_res.under;
            if (state_reg != ST_LOAD) begin
                range_next = alu_res.range;
                count_next = alu_res.count;
            end
        end
        case (state_reg)
            ST_LOAD: begin
                load_idx_next = load_idx_reg + 2'd1;
                if (load_idx_reg == LOAD_LAST) begin
                    range_next = RANGE_INIT;
                    count_next = COUNT_INIT;
                end
            end
            ST_DECIDE: begin
                result_next = DECODED_W'(alu_res.bit_out);
            end
            ST_LITERAL: begin
                result_next   = {result_reg[DECODED_W-2:0], alu_res.bit_out};
                lit_left_next = lit_left_reg - 1'b1;
            end
            default: begin
                result_next = result_next;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            range_reg <= RANGE_INIT;
            value_reg <= '0;
            count_reg <= COUNT_INIT;
        end else begin
            state_reg <= state_next;
            range_reg <= range_next;
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        split_reg    <= split_next;
        lit_left_reg <= lit_left_next;
        load_idx_reg <= load_idx_next;
        result_reg   <= result_next;
        under_reg    <= under_next;
        over_reg     <= over_next;
    end

    assign rsp.decoded   = result_reg;
    assign rsp.underflow = under_reg;
    assign rsp.overflow  = over_reg;

endmodule

`default_nettype wire

// ----- rtl/core/boolean_arithmetic_decoder_top.sv -----
// ---------------------------------------------------------------------------
// Boolean arithmetic decoder
// Binary arithmetic entropy decoder with an input byte FIFO.
// ---------------------------------------------------------------------------
// Each request carries one command in s_tuser and gives exactly one response.
// The block handles one request at a time and steps a single shared
// compare, subtract and shift unit once per cycle. After the accepting edge
// a push goes straight to the done state, a start loads four FIFO bytes in
// the load state (one FIFO byte per cycle), a bool passes the decide state
// and then the renormalize state, shifting while range is below 0x80, and
// a literal of n bits stays in the literal state for one step per decoded
// bit. s_tready rises again together with m_tvalid. The
// response is held in an output register, so the next request can be
// accepted while it waits; a further response waits inside the block until
// the first one is taken. Underflow and overflow are reported in m_tuser.
`default_nettype none

module boolean_arithmetic_decoder_top (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // s_tdata: byte_in [7:0], probability [15:8], literal_bits [20:16], zero [23:21]
    input  wire  [23:0] s_tdata,
    // s_tuser: cmd [1:0]
    input  wire  [1:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // m_tdata: decoded [15:0], zero [23:16]
    output logic [23:0] m_tdata,
    // m_tuser: underflow [0], overflow [1]
    output logic [1:0]  m_tuser
);
    import bdec_pkg::*;

    req_t       req;
    rsp_t       rsp;
    fifo_stat_t fifo_stat;
    fifo_ctrl_t fifo_ctrl;
    logic       rsp_valid, rsp_ready;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [DECODED_W-1:0] decoded_reg, decoded_next;
    logic [1:0]           flags_reg, flags_next;

    assign req.cmd          = cmd_t'(s_tuser);
    assign req.byte_in      = s_tdata[7:0];
    assign req.probability  = s_tdata[15:8];
    assign req.literal_bits = s_tdata[16 +: NBITS_W];

    bdec_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (fifo_ctrl),
        .stat    (fifo_stat)
    );

    bdec_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .fifo_stat (fifo_stat),
        .fifo_ctrl (fifo_ctrl)
    );

    assign rsp_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        decoded_next  = decoded_reg;
        flags_next    = flags_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (rsp_valid && rsp_ready) begin
            m_tvalid_next = 1'b1;
            decoded_next  = rsp.decoded;
            flags_next    = {rsp.overflow, rsp.underflow};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        decoded_reg <= decoded_next;
        flags_reg   <= flags_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(24 - DECODED_W)'(0), decoded_reg};
    assign m_tuser  = flags_reg;

    // The FIFO can never report empty and full together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fifo_stat.empty && fifo_stat.full))
        else $error("FIFO reports empty and full at once");

    // Once a request is accepted, s_tready drops before the next one is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Request accepted on back-to-back cycles");

    // An overflow only comes from a push, whose decoded value is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[15:0] == 16'd0) && !m_tuser[0])
        else $error("Overflow response carries decoded data or underflow");

endmodule

`default_nettype wire
